@@ rtl/ffsp_pkg.sv @@
// ----------------------------------------------------------------------------
// ffsp_pkg: shared types and constants of the feedback frame sync parser
// Frame layout, sync word, register indexes and the records passed between
// the byte front end, the frame queue and the result back end.
// ----------------------------------------------------------------------------
package ffsp_pkg;

	localparam logic [15:0] SYNC_WORD   = 16'hABCD;
	localparam int          FRAME_BYTES = 18;
	localparam int          LATCH_WORDS = 8;
	localparam int          POS_W       = 5;
	localparam int          QUEUE_DEPTH_DEF = 2;

	// Frame word indexes.
	localparam int W_ECHO_FIRST  = 1;
	localparam int W_ECHO_SECOND = 2;
	localparam int W_RIGHT_SPEED = 3;
	localparam int W_LEFT_SPEED  = 4;
	localparam int W_BATTERY     = 5;
	localparam int W_TEMPERATURE = 6;
	localparam int W_LED         = 7;

	localparam logic signed [15:0] BATTERY_MIN_RST       = 16'sd1500;
	localparam logic signed [15:0] BATTERY_MAX_RST       = 16'sd6000;
	localparam logic signed [15:0] TEMPERATURE_MIN_RST   = -16'sd400;
	localparam logic signed [15:0] TEMPERATURE_LIMIT_RST = 16'sd900;

	typedef enum logic [1:0] {
		CFG_BATTERY_MIN       = 2'd0,
		CFG_BATTERY_MAX       = 2'd1,
		CFG_TEMPERATURE_MIN   = 2'd2,
		CFG_TEMPERATURE_LIMIT = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic signed [15:0] battery_min;
		logic signed [15:0] battery_max;
		logic signed [15:0] temperature_min;
		logic signed [15:0] temperature_limit;
	} cfg_t;

	// One completed frame: check result and words 1..7.
	typedef struct packed {
		logic                              ok;
		logic [LATCH_WORDS-1:1][15:0]      words;
	} frame_rec_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

endpackage

@@ rtl/ffsp_front.sv @@
// ----------------------------------------------------------------------------
// ffsp_front: byte front end
// Detects the sync word, assembles the frame word by word with a running
// XOR, and emits one frame record when the checksum word arrives.
// ----------------------------------------------------------------------------
module ffsp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	input  logic [7:0]            rx_byte,
	output logic                  rec_push,
	output ffsp_pkg::frame_rec_t  rec
);
	import ffsp_pkg::*;

	localparam logic [POS_W-1:0] POS_START = POS_W'(2);
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);

	logic [7:0]                   prev_q;
	logic [POS_W-1:0]             pos_q;
	logic [7:0]                   lo_q;
	logic [15:0]                  xor_q;
	logic [LATCH_WORDS-1:0][15:0] words_q;

	logic        sync;
	logic        open;
	logic [15:0] word;
	logic [3:0]  widx;

	assign sync = (rx_byte == SYNC_WORD[15:8]) && (prev_q == SYNC_WORD[7:0]);
	assign open = (pos_q >= POS_START) && (pos_q <= POS_LAST);
	assign word = {rx_byte, lo_q};
	assign widx = pos_q[POS_W-1:1];

	// A frame completes on the high byte of the checksum word, unless that
	// byte also closes a sync word, which restarts assembly instead.
	assign rec_push = byte_valid && !sync && (pos_q == POS_LAST);
	assign rec.ok   = (words_q[0] == SYNC_WORD) && (xor_q == word);
	assign rec.words = words_q[LATCH_WORDS-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			pos_q  <= '0;
		end else if (byte_valid) begin
			prev_q <= rx_byte;
			if (sync) begin
				pos_q <= POS_START;
			end else if (pos_q == POS_LAST) begin
				pos_q <= '0;
			end else if (open) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid) begin
			if (sync) begin
				words_q[0] <= SYNC_WORD;
				xor_q      <= SYNC_WORD;
			end else if (open) begin
				if (!pos_q[0]) begin
					lo_q <= rx_byte;
				end else if (widx < 4'(LATCH_WORDS)) begin
					words_q[widx[2:0]] <= word;
					xor_q              <= xor_q ^ word;
				end
			end
		end
	end

endmodule

@@ rtl/ffsp_queue.sv @@
// ----------------------------------------------------------------------------
// ffsp_queue: frame record queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module ffsp_queue #(
	parameter int DEPTH = ffsp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ffsp_pkg::frame_rec_t  wr_rec,
	input  logic                  pop,
	output ffsp_pkg::frame_rec_t  rd_rec,
	output ffsp_pkg::q_stat_t     stat
);
	import ffsp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	frame_rec_t              mem_q [DEPTH];
	logic [PTR_W-1:0]        wr_ptr_q;
	logic [PTR_W-1:0]        rd_ptr_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    do_push;
	logic                    do_pop;

	assign stat.valid = (cnt_q != '0);
	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && stat.valid;
	assign rd_rec     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

endmodule

@@ rtl/ffsp_back.sv @@
// ----------------------------------------------------------------------------
// ffsp_back: result back end
// Applies one frame record to the latched words, the counters and the power
// fault flag; these registers are the result register itself.
// ----------------------------------------------------------------------------
module ffsp_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ffsp_pkg::cfg_t             cfg,
	input  ffsp_pkg::q_stat_t          q_stat,
	input  ffsp_pkg::frame_rec_t       rec,
	output logic                       rec_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       frame_valid,
	output logic [ffsp_pkg::LATCH_WORDS-1:1][15:0] latched,
	output logic                       power_fault,
	output logic [31:0]                good_frames,
	output logic [31:0]                bad_frames
);
	import ffsp_pkg::*;

	logic               fault_new;
	logic signed [15:0] bat;
	logic signed [15:0] tmp;

	assign rec_pop = q_stat.valid && (!out_valid || out_ready);
	assign bat     = $signed(rec.words[W_BATTERY]);
	assign tmp     = $signed(rec.words[W_TEMPERATURE]);
	assign fault_new = (bat < cfg.battery_min) || (bat > cfg.battery_max) ||
	                   (tmp < cfg.temperature_min) || (tmp >= cfg.temperature_limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid   <= 1'b0;
			frame_valid <= 1'b0;
			latched     <= '0;
			power_fault <= 1'b0;
			good_frames <= '0;
			bad_frames  <= '0;
		end else begin
			if (rec_pop) begin
				out_valid   <= 1'b1;
				frame_valid <= rec.ok;
				if (rec.ok) begin
					latched     <= rec.words;
					power_fault <= fault_new;
					good_frames <= good_frames + 32'd1;
				end else begin
					bad_frames <= bad_frames + 32'd1;
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/feedback_frame_sync_parser.sv @@
// ----------------------------------------------------------------------------
// feedback_frame_sync_parser: sync word frame parser with XOR checksum
// Top level: configuration registers, front end, frame queue and back end.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, rx_byte) takes one received byte per
// beat, one beat per cycle. The byte pair 0xCD then 0xAB restarts frame
// assembly at any point; after 18 bytes the frame is checked and one result
// beat leaves on the output channel (out_valid, out_ready and the fields).
// The latched fields and power_fault show the last good frame.
// A completed frame is written into the frame queue, and the back end then
// registers its result from the queue head. Throughput: one byte per cycle;
// in_ready drops only while the frame queue (QUEUE_DEPTH records) is full,
// which happens only when the receiver stalls results over several frames.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and writes the four limits; write it only while idle.
// Reset clears the counters, latched words, fault flag and any open frame,
// and loads the default limits.
// ----------------------------------------------------------------------------
module feedback_frame_sync_parser #(
	parameter int QUEUE_DEPTH = ffsp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               frame_valid,
	output logic signed [15:0] left_wheel_speed,
	output logic signed [15:0] right_wheel_speed,
	output logic signed [15:0] battery_level,
	output logic signed [15:0] board_temperature,
	output logic signed [15:0] echo_first,
	output logic signed [15:0] echo_second,
	output logic [15:0]        led_word,
	output logic               power_fault,
	output logic [31:0]        good_frames,
	output logic [31:0]        bad_frames
);
	import ffsp_pkg::*;

	cfg_t                         cfg_q;
	frame_rec_t                   push_rec;
	frame_rec_t                   head_rec;
	q_stat_t                      q_stat;
	logic                         push;
	logic                         pop;
	logic                         byte_take;
	logic [LATCH_WORDS-1:1][15:0] latched;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_stat.full;
	assign byte_take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.battery_min       <= BATTERY_MIN_RST;
			cfg_q.battery_max       <= BATTERY_MAX_RST;
			cfg_q.temperature_min   <= TEMPERATURE_MIN_RST;
			cfg_q.temperature_limit <= TEMPERATURE_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_BATTERY_MIN:       cfg_q.battery_min       <= $signed(cfg_data);
				CFG_BATTERY_MAX:       cfg_q.battery_max       <= $signed(cfg_data);
				CFG_TEMPERATURE_MIN:   cfg_q.temperature_min   <= $signed(cfg_data);
				CFG_TEMPERATURE_LIMIT: cfg_q.temperature_limit <= $signed(cfg_data);
				default:               cfg_q <= cfg_q;
			endcase
		end
	end

	ffsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_take),
		.rx_byte    (rx_byte),
		.rec_push   (push),
		.rec        (push_rec)
	);

	ffsp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (push_rec),
		.pop    (pop),
		.rd_rec (head_rec),
		.stat   (q_stat)
	);

	ffsp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_stat      (q_stat),
		.rec         (head_rec),
		.rec_pop     (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.frame_valid (frame_valid),
		.latched     (latched),
		.power_fault (power_fault),
		.good_frames (good_frames),
		.bad_frames  (bad_frames)
	);

	assign echo_first        = $signed(latched[W_ECHO_FIRST]);
	assign echo_second       = $signed(latched[W_ECHO_SECOND]);
	assign right_wheel_speed = $signed(latched[W_RIGHT_SPEED]);
	assign left_wheel_speed  = $signed(latched[W_LEFT_SPEED]);
	assign battery_level     = $signed(latched[W_BATTERY]);
	assign board_temperature = $signed(latched[W_TEMPERATURE]);
	assign led_word          = latched[W_LED];

	// A completed frame is never dropped: the queue has room whenever a byte
	// is taken.
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("frame record pushed into a full queue");

	// A waiting result keeps the counters it reports.
	a_counts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(good_frames) && $stable(bad_frames))
		else $error("counters changed under a stalled result");

	// A queued frame follows a taken result in the next cycle.
	a_back_refills: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && q_stat.valid |=> out_valid)
		else $error("back end idled with a queued frame");

endmodule

@@ sim/frame_result_checker.sv @@
// ----------------------------------------------------------------------------
// frame_result_checker: result prediction and comparison for the frame parser
// Follows the limit writes and every accepted byte beat, rebuilds the frames
// on its own, and compares each result beat field by field with the oldest
// predicted frame result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module frame_result_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         rx_byte,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               frame_valid,
	input  logic signed [15:0] left_wheel_speed,
	input  logic signed [15:0] right_wheel_speed,
	input  logic signed [15:0] battery_level,
	input  logic signed [15:0] board_temperature,
	input  logic signed [15:0] echo_first,
	input  logic signed [15:0] echo_second,
	input  logic [15:0]        led_word,
	input  logic               power_fault,
	input  logic [31:0]        good_frames,
	input  logic [31:0]        bad_frames,
	output int unsigned        failures,
	output int unsigned        outstanding,
	output int unsigned        frames_checked
);
	import ffsp_pkg::*;

	typedef struct {
		logic               frame_valid;
		logic signed [15:0] left_wheel_speed;
		logic signed [15:0] right_wheel_speed;
		logic signed [15:0] battery_level;
		logic signed [15:0] board_temperature;
		logic signed [15:0] echo_first;
		logic signed [15:0] echo_second;
		logic [15:0]        led_word;
		logic               power_fault;
		logic [31:0]        good_frames;
		logic [31:0]        bad_frames;
	} frame_result_t;

	logic signed [15:0] battery_min_q;
	logic signed [15:0] battery_max_q;
	logic signed [15:0] temperature_min_q;
	logic signed [15:0] temperature_limit_q;

	logic [7:0]    last_byte;
	int            fill;
	logic [7:0]    frame_bytes [FRAME_BYTES];
	logic [15:0]   held_words [1:LATCH_WORDS-1];
	logic [31:0]   good_total;
	logic [31:0]   bad_total;
	logic          fault_now;
	frame_result_t expected_frames [$];
	int unsigned   mismatch_count;
	int unsigned   checked_count;

	// A sync pair restarts assembly even inside an open frame, and it wins over
	// completion when it lands on the last byte.
	task automatic absorb_byte(input logic [7:0] b);
		logic [15:0]        word [9];
		logic [15:0]        parity;
		logic signed [15:0] bat;
		logic signed [15:0] tmp;
		frame_result_t      rec;
		int                 i;
		if ({b, last_byte} == SYNC_WORD) begin
			frame_bytes[0] = last_byte;
			frame_bytes[1] = b;
			fill = 2;
		end else if (fill >= 2 && fill < FRAME_BYTES) begin
			frame_bytes[fill] = b;
			fill++;
		end
		if (fill == FRAME_BYTES) begin
			parity = '0;
			for (i = 0; i < 9; i++) begin
				word[i] = {frame_bytes[2*i+1], frame_bytes[2*i]};
				if (i < LATCH_WORDS)
					parity ^= word[i];
			end
			rec.frame_valid = (word[0] == SYNC_WORD) && (parity == word[8]);
			if (rec.frame_valid) begin
				for (i = 1; i < LATCH_WORDS; i++)
					held_words[i] = word[i];
				good_total++;
				bat = held_words[W_BATTERY];
				tmp = held_words[W_TEMPERATURE];
				fault_now = bat < battery_min_q || bat > battery_max_q ||
					tmp < temperature_min_q || tmp >= temperature_limit_q;
			end else begin
				bad_total++;
			end
			rec.left_wheel_speed  = held_words[W_LEFT_SPEED];
			rec.right_wheel_speed = held_words[W_RIGHT_SPEED];
			rec.battery_level     = held_words[W_BATTERY];
			rec.board_temperature = held_words[W_TEMPERATURE];
			rec.echo_first        = held_words[W_ECHO_FIRST];
			rec.echo_second       = held_words[W_ECHO_SECOND];
			rec.led_word          = held_words[W_LED];
			rec.power_fault       = fault_now;
			rec.good_frames       = good_total;
			rec.bad_frames        = bad_total;
			expected_frames.push_back(rec);
			fill = 0;
		end
		last_byte = b;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: result %0d field %s: expected %0h, actual %0h",
					$time, checked_count, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		int            i;
		if (!arst_n) begin
			battery_min_q       = BATTERY_MIN_RST;
			battery_max_q       = BATTERY_MAX_RST;
			temperature_min_q   = TEMPERATURE_MIN_RST;
			temperature_limit_q = TEMPERATURE_LIMIT_RST;
			last_byte = '0;
			fill = 0;
			for (i = 1; i < LATCH_WORDS; i++)
				held_words[i] = '0;
			good_total = '0;
			bad_total = '0;
			fault_now = 1'b0;
			expected_frames.delete();
			mismatch_count = 0;
			checked_count = 0;
			failures <= 0;
			outstanding <= 0;
			frames_checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index_t'(cfg_index))
					CFG_BATTERY_MIN:       battery_min_q = cfg_data;
					CFG_BATTERY_MAX:       battery_max_q = cfg_data;
					CFG_TEMPERATURE_MIN:   temperature_min_q = cfg_data;
					CFG_TEMPERATURE_LIMIT: temperature_limit_q = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				absorb_byte(rx_byte);
			if (out_valid && out_ready) begin
				if (expected_frames.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result beat with no completed frame pending", $time);
				end else begin
					want = expected_frames.pop_front();
					compare_field("frame_valid", 32'(want.frame_valid), 32'(frame_valid));
					compare_field("left_wheel_speed", 32'(want.left_wheel_speed),
						32'(left_wheel_speed));
					compare_field("right_wheel_speed", 32'(want.right_wheel_speed),
						32'(right_wheel_speed));
					compare_field("battery_level", 32'(want.battery_level),
						32'(battery_level));
					compare_field("board_temperature", 32'(want.board_temperature),
						32'(board_temperature));
					compare_field("echo_first", 32'(want.echo_first), 32'(echo_first));
					compare_field("echo_second", 32'(want.echo_second), 32'(echo_second));
					compare_field("led_word", 32'(want.led_word), 32'(led_word));
					compare_field("power_fault", 32'(want.power_fault), 32'(power_fault));
					compare_field("good_frames", want.good_frames, good_frames);
					compare_field("bad_frames", want.bad_frames, bad_frames);
				end
				checked_count++;
			end
			failures <= mismatch_count;
			outstanding <= expected_frames.size();
			frames_checked <= checked_count;
		end
	end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: byte stream stimulus for the feedback frame sync parser
// Sends directed frames for the limit edges and sync corner cases, then
// random frames, broken frames and line noise under several limit settings,
// with bursty byte traffic and a stalling result receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import ffsp_pkg::*;

	localparam int CYCLE_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_BYTES   = 80;
	localparam int MIN_RESULTS   = 30;

	typedef enum int {FK_GOOD, FK_BAD_SUM, FK_BAD_BODY, FK_CUT, FK_LAST_SYNC} frame_kind_t;
	typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_t;
	typedef logic [LATCH_WORDS-1:1][15:0] frame_body_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_ready;
	logic               frame_valid;
	logic signed [15:0] left_wheel_speed;
	logic signed [15:0] right_wheel_speed;
	logic signed [15:0] battery_level;
	logic signed [15:0] board_temperature;
	logic signed [15:0] echo_first;
	logic signed [15:0] echo_second;
	logic [15:0]        led_word;
	logic               power_fault;
	logic [31:0]        good_frames;
	logic [31:0]        bad_frames;
	int unsigned        failures;
	int unsigned        outstanding;
	int unsigned        frames_checked;

	int                 burst_left;
	int                 bytes_sent;
	int                 hold_count;
	logic signed [15:0] bat_lo;
	logic signed [15:0] bat_hi;
	logic signed [15:0] tmp_lo;
	logic signed [15:0] tmp_hi;

	feedback_frame_sync_parser dut (.*);

	frame_result_checker frame_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sender pacing: bursts of random length, some long, each followed by a gap.
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
				$urandom_range(0, 20);
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		pace();
	endtask

	task automatic send_frame(input frame_body_t body, input frame_kind_t kind);
		logic [7:0]  octets [FRAME_BYTES];
		logic [15:0] parity;
		int          count;
		int          pick;
		int          i;
		octets[0] = SYNC_WORD[7:0];
		octets[1] = SYNC_WORD[15:8];
		parity = SYNC_WORD;
		for (i = 1; i < LATCH_WORDS; i++) begin
			octets[2*i]   = body[i][7:0];
			octets[2*i+1] = body[i][15:8];
			parity ^= body[i];
		end
		octets[FRAME_BYTES-2] = parity[7:0];
		octets[FRAME_BYTES-1] = parity[15:8];
		count = FRAME_BYTES;
		case (kind)
			FK_BAD_SUM: begin
				pick = $urandom_range(FRAME_BYTES - 2, FRAME_BYTES - 1);
				octets[pick] = octets[pick] ^ (8'h01 << $urandom_range(0, 7));
			end
			FK_BAD_BODY: begin
				pick = $urandom_range(2, FRAME_BYTES - 3);
				octets[pick] = octets[pick] ^ (8'h01 << $urandom_range(0, 7));
			end
			FK_CUT: count = $urandom_range(2, FRAME_BYTES - 1);
			FK_LAST_SYNC: begin
				// The sync pair on the final two bytes reopens the frame instead.
				octets[FRAME_BYTES-2] = SYNC_WORD[7:0];
				octets[FRAME_BYTES-1] = SYNC_WORD[15:8];
			end
			default: ;
		endcase
		for (i = 0; i < count; i++)
			send_byte(octets[i]);
		bytes_sent += count;
	endtask

	function automatic frame_body_t frame_body(input logic [15:0] e1, e2, spd_r, spd_l,
			bat, tmp, led);
		frame_body_t body;
		body[W_ECHO_FIRST]  = e1;
		body[W_ECHO_SECOND] = e2;
		body[W_RIGHT_SPEED] = spd_r;
		body[W_LEFT_SPEED]  = spd_l;
		body[W_BATTERY]     = bat;
		body[W_TEMPERATURE] = tmp;
		body[W_LED]         = led;
		return body;
	endfunction

	function automatic logic [15:0] any_word();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] near_limit(input logic [15:0] lo, hi);
		logic [15:0] pivot;
		pivot = $urandom_range(0, 1) ? lo : hi;
		case ($urandom_range(0, 4))
			0: return pivot - 16'd1;
			1: return pivot;
			2: return pivot + 16'd1;
			default: return any_word();
		endcase
	endfunction

	task automatic send_random_frame();
		frame_kind_t kind;
		int          roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			kind = FK_GOOD;
		else if (roll < 78)
			kind = FK_BAD_SUM;
		else if (roll < 86)
			kind = FK_BAD_BODY;
		else if (roll < 93)
			kind = FK_CUT;
		else
			kind = FK_LAST_SYNC;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
		send_frame(frame_body(any_word(), any_word(), any_word(), any_word(),
			near_limit(bat_lo, bat_hi), near_limit(tmp_lo, tmp_hi), any_word()), kind);
	endtask

	task automatic put_reg(input cfg_index_t idx, input logic [15:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_limits(input logic signed [15:0] lo_bat, hi_bat, lo_tmp, hi_tmp);
		cfg_valid <= 1'b1;
		put_reg(CFG_BATTERY_MIN, lo_bat);
		put_reg(CFG_BATTERY_MAX, hi_bat);
		put_reg(CFG_TEMPERATURE_MIN, lo_tmp);
		put_reg(CFG_TEMPERATURE_LIMIT, hi_tmp);
		cfg_valid <= 1'b0;
		bat_lo = lo_bat;
		bat_hi = hi_bat;
		tmp_lo = lo_tmp;
		tmp_hi = hi_tmp;
	endtask

	// Stop sending, wait for every predicted result, then let the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int phase;
		int phase_start;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BATTERY_MIN;
		cfg_data = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		hold_count = 0;
		burst_left = 0;
		bytes_sent = 0;
		bat_lo = BATTERY_MIN_RST;
		bat_hi = BATTERY_MAX_RST;
		tmp_lo = TEMPERATURE_MIN_RST;
		tmp_hi = TEMPERATURE_LIMIT_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Bytes before any sync are dropped, including a lone second sync byte.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(SYNC_WORD[15:8]);
		send_frame(frame_body(16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'd3700, 16'd250,
			16'h5A5A), FK_GOOD);
		send_frame(frame_body(16'h1234, 16'h0001, 16'h0000, 16'hFFFF, 16'd1500, 16'd899,
			16'hFFFF), FK_GOOD);
		send_frame(frame_body(16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00, 16'd6000, -16'sd400,
			16'h0000), FK_GOOD);
		send_frame(frame_body(16'hAAAA, 16'h5555, 16'h0100, 16'h0010, 16'd1499, 16'd100,
			16'h0F0F), FK_GOOD);
		send_frame(frame_body(16'h5555, 16'hAAAA, 16'h0010, 16'h0100, 16'd6001, 16'd100,
			16'hF0F0), FK_GOOD);
		// A bad frame must leave the latched words and the fault flag alone.
		send_frame(frame_body(16'h0F0F, 16'hF0F0, 16'h1111, 16'h2222, 16'd3000, 16'd0,
			16'h3333), FK_BAD_SUM);
		send_frame(frame_body(16'h0202, 16'h0303, 16'h0404, 16'h0505, 16'd3000, 16'd900,
			16'h0606), FK_GOOD);
		send_frame(frame_body(16'h0707, 16'h0808, 16'h0909, 16'h0A0A, 16'd3000, -16'sd401,
			16'h0B0B), FK_GOOD);
		send_frame(frame_body(16'h4444, 16'h4444, 16'h4444, 16'h4444, 16'd3000, 16'd0,
			16'h4444), FK_BAD_BODY);
		send_frame(frame_body(16'h1357, 16'h2468, 16'h9BDF, 16'hACE0, 16'd4000, 16'd300,
			16'h8001), FK_CUT);
		send_frame(frame_body(16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'd4000, 16'd300,
			16'h0005), FK_GOOD);
		send_frame(frame_body(16'h0006, 16'h0007, 16'h0008, 16'h0009, 16'd4000, 16'd300,
			16'h000A), FK_LAST_SYNC);
		send_frame(frame_body(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF,
			16'hFFFF), FK_GOOD);

		for (phase = 1; phase <= 5; phase++) begin
			drain();
			case (phase)
				1: apply_limits(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
				2: apply_limits(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
				3: apply_limits(BATTERY_MIN_RST, BATTERY_MAX_RST, TEMPERATURE_MIN_RST,
					TEMPERATURE_LIMIT_RST);
				default: apply_limits(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
			endcase
			// The receiver holds off while bytes keep coming, so the frame queue fills.
			if (phase == 3) begin
				hold_count <= hold_count + 1;
				burst_left = 400;
			end
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES ||
					(phase == 5 && frames_checked + outstanding < MIN_RESULTS))
				send_random_frame();
		end

		drain();
		if (failures == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : result_sink
		rx_mode_t mode;
		int       stretch;
		int       hold_left;
		int       holds_seen;
		int       tick;
		out_ready = 1'b0;
		mode = RX_ALWAYS;
		stretch = 0;
		hold_left = 0;
		holds_seen = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_count != holds_seen) begin
				holds_seen = hold_count;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (stretch == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					stretch = $urandom_range(10, 80);
				end
				stretch--;
				case (mode)
					RX_ALWAYS: out_ready <= 1'b1;
					RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= (tick % 3 != 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < CYCLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

endmodule
